FILE: design/bfsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shortest-path block.
// No dependencies; every other file of the block imports it.
package bfsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 64;
    localparam int WEIGHT_BITS  = 16;

    localparam int VID_W        = 4;
    localparam int VCNT_W       = 5;
    localparam int DIST_W       = 24;
    localparam int SUM_W        = DIST_W + 1;
    localparam int FIELD_WGT_W  = 16;
    localparam int EDGE_IDX_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CNT_W   = $clog2(MAX_EDGES + 1);

    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;
    localparam int ACT_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 2'd1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_VERT,
        ST_READ,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [VID_W-1:0]             from_v;
        logic [VID_W-1:0]             to_v;
        logic signed [WEIGHT_BITS-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] value;
    } relax_t;

endpackage

FILE: design/bfsp_edge_ram.sv
`timescale 1ns / 1ps
// Edge table memory: one write port and one registered read port.
// Depends on bfsp_pkg for the depth and the edge entry type.
module bfsp_edge_ram (
    input  logic                             clk,
    input  logic                             we,
    input  logic [bfsp_pkg::EDGE_IDX_W-1:0]  waddr,
    input  bfsp_pkg::edge_t                  wdata,
    input  logic [bfsp_pkg::EDGE_IDX_W-1:0]  raddr,
    output bfsp_pkg::edge_t                  rdata
);
    import bfsp_pkg::*;

    edge_t mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bfsp_relax_unit.sv
`timescale 1ns / 1ps
// Shared relaxation unit: exact add of distance and weight, compare, saturate.
// Depends on bfsp_pkg for widths and the result type.
module bfsp_relax_unit (
    input  logic signed [bfsp_pkg::DIST_W-1:0]      base_dist,
    input  logic signed [bfsp_pkg::WEIGHT_BITS-1:0] weight,
    input  logic signed [bfsp_pkg::DIST_W-1:0]      tgt_dist,
    input  logic                                    tgt_reached,
    output bfsp_pkg::relax_t                        result
);
    import bfsp_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] tgt_ext;

    always_comb
    begin
        sum     = SUM_W'(base_dist) + SUM_W'(weight);
        tgt_ext = SUM_W'(tgt_dist);
        result.hit = !tgt_reached || (sum < tgt_ext);
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            result.value = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            result.value = sum[DIST_W-1:0];
        end
    end

endmodule

FILE: design/bellman_ford_shortest_paths.sv
`timescale 1ns / 1ps
// Top level of the single-source shortest-path block and its sequencer.
// Depends on bfsp_pkg, bfsp_edge_ram and bfsp_relax_unit.
//
// Items enter on the s_axis channel; tuser selects load edge, run or clear.
// A load or a clear is taken while the block is idle. A run holds s_axis_tready low while it
// sweeps the edge table: n sweeps (n-1 relaxing passes and one cycle check),
// each visiting the vertices in order and, for every reached vertex, reading
// all loaded edges in turn through the single edge table read port and the
// one shared relaxation unit. It then emits n result items on m_axis, one
// per cycle when the receiver is ready; tlast marks the final vertex. A
// stalled receiver holds the output register and the sequencer waits for it.
// The cfg channel is always ready; the user must write it only while the
// block is idle, and the block itself does not enforce this. Reset empties
// the edge table, clears the dropped-edge flag and sets source 0 and vertex
// count 5.
module bellman_ford_shortest_paths (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // edge_from[3:0], edge_to[7:4], edge_weight[23:8]
    input  logic [bfsp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [bfsp_pkg::ACT_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vertex[3:0], distance[27:4], predecessor[31:28], reachable[32],
    // negative_cycle[33], edges_dropped[34], zero fill[39:35]
    output logic [bfsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfsp_pkg::*;

    state_t                        state_reg, state_next;
    logic [VID_W-1:0]              source_reg;
    logic [VCNT_W-1:0]             vcount_reg;
    logic [EDGE_CNT_W-1:0]         total_reg, total_next;
    logic                          dropped_reg, dropped_next;
    logic [VCNT_W-1:0]             u_reg, u_next;
    logic [EDGE_IDX_W-1:0]         e_reg, e_next;
    logic [VCNT_W-1:0]             sweep_reg, sweep_next;
    logic                          found_reg, found_next;
    logic                          cycle_reg, cycle_next;
    logic signed [DIST_W-1:0]      cur_dist_reg, cur_dist_next;
    logic                          m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]        m_data_reg, m_data_next;
    logic                          m_last_reg, m_last_next;

    logic signed [DIST_W-1:0]      dist_mem [MAX_VERTICES];
    logic [VID_W-1:0]              parent_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]       reached_reg, reached_next;

    logic [VCNT_W-1:0]             n_used;
    logic                          in_accept;
    action_t                       in_action;
    edge_t                         in_edge;
    edge_t                         edge_q;
    logic                          ram_we;
    logic [VID_W-1:0]              rd_addr;
    logic signed [DIST_W-1:0]      rd_dist;
    logic [VID_W-1:0]              rd_parent;
    logic                          st_we;
    logic [VID_W-1:0]              st_waddr;
    logic signed [DIST_W-1:0]      st_wdist;
    logic [VID_W-1:0]              st_wparent;
    relax_t                        relax;
    logic                          edge_used;
    logic                          last_edge;
    logic                          check_sweep;
    logic                          vtx_reached;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_action     = action_t'(s_axis_tuser);
    assign in_edge.from_v = s_axis_tdata[VID_W-1:0];
    assign in_edge.to_v   = s_axis_tdata[2*VID_W-1:VID_W];
    assign in_edge.weight = s_axis_tdata[2*VID_W+WEIGHT_BITS-1:2*VID_W];

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_used = VCNT_W'(1);
        end
        else if (vcount_reg > VCNT_W'(MAX_VERTICES))
        begin
            n_used = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_used = vcount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= '0;
            vcount_reg <= VCNT_W'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SOURCE)
            begin
                source_reg <= cfg_data[VID_W-1:0];
            end
            else if (cfg_index == REG_VCOUNT)
            begin
                vcount_reg <= cfg_data[VCNT_W-1:0];
            end
        end
    end

    assign ram_we = in_accept && (in_action == ACT_LOAD) &&
                    (total_reg < EDGE_CNT_W'(MAX_EDGES));

    bfsp_edge_ram u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (total_reg[EDGE_IDX_W-1:0]),
        .wdata (in_edge),
        .raddr (e_reg),
        .rdata (edge_q)
    );

    assign rd_addr     = (state_reg == ST_EVAL) ? edge_q.to_v : u_reg[VID_W-1:0];
    assign rd_dist     = dist_mem[rd_addr];
    assign rd_parent   = parent_mem[rd_addr];
    assign vtx_reached = reached_reg[rd_addr];

    bfsp_relax_unit u_relax (
        .base_dist   (cur_dist_reg),
        .weight      (edge_q.weight),
        .tgt_dist    (rd_dist),
        .tgt_reached (vtx_reached),
        .result      (relax)
    );

    assign edge_used   = ({1'b0, edge_q.from_v} == u_reg) && ({1'b0, edge_q.to_v} < n_used);
    assign last_edge   = (EDGE_CNT_W'(e_reg) + EDGE_CNT_W'(1)) == total_reg;
    assign check_sweep = (sweep_reg == n_used);

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        dropped_next  = dropped_reg;
        u_next        = u_reg;
        e_next        = e_reg;
        sweep_next    = sweep_reg;
        found_next    = found_reg;
        cycle_next    = cycle_reg;
        cur_dist_next = cur_dist_reg;
        reached_next  = reached_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        st_we         = 1'b0;
        st_waddr      = source_reg;
        st_wdist      = '0;
        st_wparent    = source_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_action)
                        ACT_LOAD:
                        begin
                            if (ram_we)
                            begin
                                total_next = total_reg + EDGE_CNT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            total_next   = '0;
                            dropped_next = 1'b0;
                        end
                        ACT_RUN:
                        begin
                            state_next = ST_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                reached_next = '0;
                if ({1'b0, source_reg} < n_used)
                begin
                    reached_next[source_reg] = 1'b1;
                    st_we = 1'b1;
                end
                u_next     = '0;
                sweep_next = VCNT_W'(1);
                found_next = 1'b0;
                state_next = ST_VERT;
            end
            ST_VERT:
            begin
                if (u_reg == n_used)
                begin
                    u_next = '0;
                    if (check_sweep)
                    begin
                        cycle_next = found_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + VCNT_W'(1);
                        found_next = 1'b0;
                    end
                end
                else if (!vtx_reached || (total_reg == '0))
                begin
                    u_next = u_reg + VCNT_W'(1);
                end
                else
                begin
                    cur_dist_next = rd_dist;
                    e_next        = '0;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (edge_used && relax.hit)
                begin
                    found_next = 1'b1;
                    if (!check_sweep)
                    begin
                        st_we      = 1'b1;
                        st_waddr   = edge_q.to_v;
                        st_wdist   = relax.value;
                        st_wparent = u_reg[VID_W-1:0];
                        reached_next[edge_q.to_v] = 1'b1;
                        if ({1'b0, edge_q.to_v} == u_reg)
                        begin
                            cur_dist_next = relax.value;
                        end
                    end
                end
                if (last_edge)
                begin
                    u_next     = u_reg + VCNT_W'(1);
                    state_next = ST_VERT;
                end
                else
                begin
                    e_next     = e_reg + EDGE_IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_TDATA_W - 2*VID_W - DIST_W - 3)'(0),
                                    dropped_reg, cycle_reg, vtx_reached,
                                    vtx_reached ? rd_parent : u_reg[VID_W-1:0],
                                    vtx_reached ? rd_dist : DIST_W'(0),
                                    u_reg[VID_W-1:0]};
                    m_last_next  = (u_reg + VCNT_W'(1)) == n_used;
                    u_next       = u_reg + VCNT_W'(1);
                    if (m_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
            u_reg       <= '0;
            e_reg       <= '0;
            sweep_reg   <= '0;
            found_reg   <= 1'b0;
            cycle_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
            u_reg       <= u_next;
            e_reg       <= e_next;
            sweep_reg   <= sweep_next;
            found_reg   <= found_next;
            cycle_reg   <= cycle_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_dist_reg <= cur_dist_next;
        reached_reg  <= reached_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        if (st_we)
        begin
            dist_mem[st_waddr]   <= st_wdist;
            parent_mem[st_waddr] <= st_wparent;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= EDGE_CNT_W'(MAX_EDGES))
        else $error("Edge count ran past the table depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> $past(total_reg) == EDGE_CNT_W'(MAX_EDGES))
        else $error("Dropped-edge flag set while the table had room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> reached_reg[u_reg[VID_W-1:0]])
        else $error("Edges scanned for a vertex that is not reached.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VERT || state_reg == ST_READ || state_reg == ST_EVAL)
        |-> (sweep_reg <= n_used) && (sweep_reg != '0))
        else $error("Sweep counter left its range during a run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && $past(state_reg == ST_VERT) |-> u_reg == '0)
        else $error("Result emission did not start at vertex zero.");

endmodule
